FILE: hdl/assert_macros.svh
// Assertion macros used by the checker of the request rate monitor.
// Every macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SWRM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("request rate monitor check failed");

// Next-cycle implication.
`define SWRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("request rate monitor check failed");

`endif

FILE: hdl/swrm_pkg.sv
// Shared types and constants of the sliding window request rate monitor.
// No dependencies; imported by every module of the block.
package swrm_pkg;

    localparam int unsigned DEFAULT_FIFO_DEPTH = 1024;

    localparam int unsigned TS_W       = 32;
    localparam int unsigned STATUS_W   = 10;
    localparam int unsigned WINDOW_W   = 24;
    localparam int unsigned CNT_OUT_W  = 11;
    localparam int unsigned ERR_W      = 32;

    localparam int unsigned S_TDATA_W  = 48;
    localparam int unsigned M_TDATA_W  = 56;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register index of the window span register.
    localparam logic [0:0] REG_WINDOW = 1'b0;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

    // Server errors: hundreds digit of the status code is 5.
    localparam int unsigned STATUS_SCALE = 100;
    localparam int unsigned ERR_DIGIT    = 5;
    localparam logic [STATUS_W-1:0] ERR_LO = STATUS_W'(ERR_DIGIT * STATUS_SCALE);
    localparam logic [STATUS_W-1:0] ERR_HI = STATUS_W'(ERR_DIGIT * STATUS_SCALE
                                                       + STATUS_SCALE - 1);

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;   // take the input transaction and push its timestamp
        logic retire;   // drop the oldest entry
        logic finish;   // update totals and load the output register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic can_retire;  // oldest entry is outside the window
    } t_sts;

endpackage

FILE: hdl/swrm_cfg.sv
// APB register file of the request rate monitor: holds the window span.
// Depends on swrm_pkg.
module swrm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swrm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [swrm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [swrm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [swrm_pkg::WINDOW_W-1:0]     o_window
);
    import swrm_pkg::*;

    logic [WINDOW_W-1:0] r_window;
    logic                wr_en;
    logic                sel_window;

    assign pready     = 1'b1;
    assign sel_window = (paddr[2] == REG_WINDOW);
    assign wr_en      = psel && penable && pwrite && pready && sel_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (wr_en) begin
            r_window <= pwdata[WINDOW_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_window) begin
            prdata = APB_DATA_W'(r_window);
        end
    end

    assign o_window = r_window;

endmodule

FILE: hdl/swrm_ctrl.sv
// Controller of the request rate monitor: sequences accept, retire and finish.
// Depends on swrm_pkg; drives swrm_datapath through t_cmd.
module swrm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    output logic            o_s_ready,
    output logic            o_m_valid,
    input  logic            i_m_ready,
    input  swrm_pkg::t_sts  i_sts,
    output swrm_pkg::t_cmd  o_cmd
);
    import swrm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.can_retire) begin
                    o_cmd.retire = 1'b1;
                end else if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.finish) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

FILE: hdl/swrm_datapath.sv
// Datapath of the request rate monitor: timestamp memory, pointers, counters
// and the output register. Depends on swrm_pkg; commanded by swrm_ctrl.
module swrm_datapath #(
    parameter int unsigned FIFO_DEPTH = swrm_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swrm_pkg::t_cmd                  i_cmd,
    output swrm_pkg::t_sts                  o_sts,
    input  logic [swrm_pkg::TS_W-1:0]       i_timestamp,
    input  logic [swrm_pkg::STATUS_W-1:0]   i_status_code,
    input  logic [swrm_pkg::WINDOW_W-1:0]   i_window,
    output logic [swrm_pkg::CNT_OUT_W-1:0]  o_in_window,
    output logic [swrm_pkg::CNT_OUT_W-1:0]  o_max_in_window,
    output logic [swrm_pkg::ERR_W-1:0]      o_server_errors,
    output logic                            o_is_server_error,
    output logic                            o_fifo_overflow
);
    import swrm_pkg::*;

    localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_DEPTH);

    logic [TS_W-1:0]  r_time_mem [FIFO_DEPTH];
    logic [TS_W-1:0]  r_rdata;

    logic [PW-1:0]    r_oldest, n_oldest;
    logic [PW-1:0]    r_newest;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_max, n_max;
    logic [ERR_W-1:0] r_err_total, n_err_total;
    logic             r_ovf;
    logic [TS_W-1:0]  r_ts;
    logic             r_is_err;

    logic [CNT_OUT_W-1:0] r_out_in_window;
    logic [CNT_OUT_W-1:0] r_out_max;
    logic [ERR_W-1:0]     r_out_errors;
    logic                 r_out_is_err;
    logic                 r_out_ovf;

    logic [PW-1:0]    oldest_inc;
    logic [PW-1:0]    newest_inc;
    logic             full;
    logic             is_err_in;
    logic [TS_W-1:0]  span;

    assign oldest_inc = (r_oldest == LAST_SLOT) ? '0 : r_oldest + PW'(1);
    assign newest_inc = (r_newest == LAST_SLOT) ? '0 : r_newest + PW'(1);
    assign full       = (r_count >= FULL_CNT);
    assign is_err_in  = (i_status_code >= ERR_LO) && (i_status_code <= ERR_HI);

    // Span from the oldest kept entry; a later oldest entry counts as zero.
    assign span = (r_ts >= r_rdata) ? (r_ts - r_rdata) : '0;
    assign o_sts.can_retire = (r_count > CW'(1)) && (span > TS_W'(i_window));

    always_comb begin
        n_oldest = r_oldest;
        n_count  = r_count;
        if (i_cmd.accept) begin
            if (full) begin
                n_oldest = oldest_inc;
                n_count  = FULL_CNT;
            end else begin
                n_count  = r_count + CW'(1);
            end
        end else if (i_cmd.retire) begin
            n_oldest = oldest_inc;
            n_count  = r_count - CW'(1);
        end
    end

    always_comb begin
        n_max = (r_count > r_max) ? r_count : r_max;
        n_err_total = r_err_total;
        if (r_is_err && (r_err_total != '1)) begin
            n_err_total = r_err_total + ERR_W'(1);
        end
    end

    // Timestamp store: one write port, one registered read of the oldest entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_time_mem[r_newest] <= i_timestamp;
        end
        r_rdata <= r_time_mem[n_oldest];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_newest    <= '0;
            r_count     <= '0;
            r_max       <= '0;
            r_err_total <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_oldest <= n_oldest;
            r_count  <= n_count;
            if (i_cmd.accept) begin
                r_newest <= newest_inc;
                if (full) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_max       <= n_max;
                r_err_total <= n_err_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ts     <= i_timestamp;
            r_is_err <= is_err_in;
        end
        if (i_cmd.finish) begin
            r_out_in_window <= CNT_OUT_W'(r_count);
            r_out_max       <= CNT_OUT_W'(n_max);
            r_out_errors    <= n_err_total;
            r_out_is_err    <= r_is_err;
            r_out_ovf       <= r_ovf;
        end
    end

    assign o_in_window       = r_out_in_window;
    assign o_max_in_window   = r_out_max;
    assign o_server_errors   = r_out_errors;
    assign o_is_server_error = r_out_is_err;
    assign o_fifo_overflow   = r_out_ovf;

endmodule

FILE: hdl/sliding_window_request_rate_monitor.sv
// Sliding window request rate monitor. Each input transaction carries one
// request (timestamp in seconds, non-decreasing, and a status code) and
// produces one output transaction with the number of requests inside the
// window, the largest such count since reset, a saturating count of 5xx
// responses, a 5xx flag for this request and a sticky overflow flag. An item
// is accepted in the idle state, then retires old entries from the window in
// the check state: the retire loop walks the timestamp memory one entry per cycle
// through its single registered read port. Retirements amortize to about one
// per item. An item finishes only when the output register is free, and that
// register lets the next item enter while a result still waits downstream.
// The timestamp memory needs no clearing after reset: only entries written
// since reset are ever read.
// Depends on swrm_pkg, swrm_cfg, swrm_ctrl and swrm_datapath.
module sliding_window_request_rate_monitor #(
    parameter int unsigned FIFO_DEPTH = swrm_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swrm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [swrm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [swrm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] timestamp, [41:32] status_code, [47:42] zero
    input  logic [swrm_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [10:0] in_window, [21:11] max_in_window, [53:22] server_errors,
    // [54] is_server_error, [55] fifo_overflow
    output logic [swrm_pkg::M_TDATA_W-1:0]    m_tdata
);
    import swrm_pkg::*;

    t_cmd                 cmd;
    t_sts                 sts;
    logic [WINDOW_W-1:0]  window;

    logic [CNT_OUT_W-1:0] in_window;
    logic [CNT_OUT_W-1:0] max_in_window;
    logic [ERR_W-1:0]     server_errors;
    logic                 is_server_error;
    logic                 fifo_overflow;

    // Window span register behind the APB port.
    swrm_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_window (window)
    );

    // Controller: accept, retire until the span fits, then finish.
    swrm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Datapath: timestamp memory, window pointers, totals, output register.
    swrm_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_timestamp       (s_tdata[TS_W-1:0]),
        .i_status_code     (s_tdata[TS_W+STATUS_W-1:TS_W]),
        .i_window          (window),
        .o_in_window       (in_window),
        .o_max_in_window   (max_in_window),
        .o_server_errors   (server_errors),
        .o_is_server_error (is_server_error),
        .o_fifo_overflow   (fifo_overflow)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_tdata = {fifo_overflow, is_server_error, server_errors,
                      max_in_window, in_window};

endmodule

FILE: hdl/swrm_checker.sv
// Port-level checks of the request rate monitor, bound to its top level.
// Depends on assert_macros.svh and sliding_window_request_rate_monitor.
`include "assert_macros.svh"

module swrm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata
);

    // An accepted request closes the input in the following cycle.
    `SWRM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // Overflow flag, once reported, stays set on every later result.
    `SWRM_ASSERT_NEXT(a_overflow_sticky, m_tvalid && m_tdata[55], !m_tvalid || m_tdata[55])

    // Window count is never zero and never above the running maximum.
    `SWRM_ASSERT_NOW(a_count_vs_max, m_tvalid,
                     (m_tdata[10:0] != 11'd0) && (m_tdata[10:0] <= m_tdata[21:11]))

    // A stalled result holds its payload.
    `SWRM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind sliding_window_request_rate_monitor swrm_checker u_swrm_checker (.*);
